// ===== hw/rtl/mips_exu_pkg.sv =====
// Package: opcodes, function codes, memory op codes and controller/datapath link types.
package mips_exu_pkg;

  localparam int unsigned XLEN = 32;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2B;
  localparam logic [5:0] OP_LL      = 6'h30;
  localparam logic [5:0] OP_SC      = 6'h38;

  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_JALR  = 6'h09;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MTHI  = 6'h11;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MTLO  = 6'h13;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_DIV   = 6'h1A;
  localparam logic [5:0] FN_DIVU  = 6'h1B;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_SUBU  = 6'h23;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_SLT   = 6'h2A;
  localparam logic [5:0] FN_SLTU  = 6'h2B;

  localparam logic [2:0] MEM_NONE = 3'd0;
  localparam logic [2:0] MEM_LW   = 3'd1;
  localparam logic [2:0] MEM_LBU  = 3'd2;
  localparam logic [2:0] MEM_LHU  = 3'd3;
  localparam logic [2:0] MEM_SB   = 3'd4;
  localparam logic [2:0] MEM_SH   = 3'd5;
  localparam logic [2:0] MEM_SW   = 3'd6;

  // Datapath operation class chosen at accept time
  typedef enum logic [1:0] {
    KIND_SIMPLE = 2'd0,
    KIND_MUL    = 2'd1,
    KIND_DIV    = 2'd2
  } kind_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture a new item and its computed result
    logic mul_lo;  // multiply step: low partial products
    logic mul_hi;  // multiply step: high partial products, write HI/LO
    logic div_step;// one restoring divide step
    logic div_fin; // write HI/LO from divider
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    kind_e kind;
    logic  div_last;
  } dp_sts_t;

  typedef struct packed {
    logic [31:0] instr_word;
    logic [31:0] instr_address;
    logic [31:0] rs_value;
    logic [31:0] rt_value;
  } exu_in_t;

  typedef struct packed {
    logic        reg_write;
    logic [4:0]  dest_reg;
    logic [31:0] write_value;
    logic [31:0] next_pc;
    logic        branch_taken;
    logic [2:0]  mem_op;
    logic [31:0] mem_address;
    logic [31:0] store_data;
  } exu_out_t;

endpackage

// ===== hw/rtl/mips_exu_if.sv =====
// Valid/ready channel interfaces for instruction and result items.
interface mips_exu_in_if;
  import mips_exu_pkg::*;
  logic    valid;
  logic    ready;
  exu_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mips_exu_out_if;
  import mips_exu_pkg::*;
  logic     valid;
  logic     ready;
  exu_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/mips_exu_ctrl.sv =====
// Controller: sequences simple, multiply and divide items and the output register.
module mips_exu_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output mips_exu_pkg::dp_cmd_t cmd_o,
  input  mips_exu_pkg::dp_sts_t sts_i
);
  import mips_exu_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL  = 2'd1,
    ST_DIV  = 2'd2,
    ST_FIN  = 2'd3
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  // Accept when idle and the result register is free or draining
  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          case (sts_i.kind)
            KIND_MUL: state_d = ST_MUL;
            KIND_DIV: state_d = ST_DIV;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_MUL: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          cmd_o.div_fin = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hw/rtl/mips_exu_dp.sv =====
// Datapath: decode, ALU, branch/jump, HI/LO, multiplier and restoring divider.
module mips_exu_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mips_exu_pkg::exu_in_t  in_i,
  input  mips_exu_pkg::dp_cmd_t  cmd_i,
  output mips_exu_pkg::dp_sts_t  sts_o,
  output mips_exu_pkg::exu_out_t out_o
);
  import mips_exu_pkg::*;

  logic [31:0] w, pc, a, b;
  logic [5:0]  op, fn;
  logic [4:0]  rt, rd, sh;
  logic [15:0] imm;
  logic [31:0] simm, zimm, seq, ea, btarget;
  logic [31:0] hi_q, lo_q;
  exu_out_t    res_d, res_q;

  assign w   = in_i.instr_word;
  assign pc  = in_i.instr_address;
  assign a   = in_i.rs_value;
  assign b   = in_i.rt_value;
  assign op  = w[31:26];
  assign rt  = w[20:16];
  assign rd  = w[15:11];
  assign sh  = w[10:6];
  assign fn  = w[5:0];
  assign imm = w[15:0];
  assign simm    = {{16{imm[15]}}, imm};
  assign zimm    = {16'h0000, imm};
  assign seq     = pc + 32'd4;
  assign ea      = a + simm;
  assign btarget = seq + {simm[29:0], 2'b00};

  // Operand registers for multi-cycle units
  logic [31:0] ma_q, mb_q;
  logic        neg_q_q, neg_r_q;
  logic [31:0] ma_d, mb_d;
  logic        is_signed;
  assign is_signed = (fn == FN_MULT) || (fn == FN_DIV);
  assign ma_d = (is_signed && a[31]) ? (32'd0 - a) : a;
  assign mb_d = (is_signed && b[31]) ? (32'd0 - b) : b;

  // Multiplier: 32x16 partial products on magnitudes, a low step then a high step
  logic [47:0] pp_lo_q;
  logic [47:0] pp_lo_d, pp_hi_d;
  logic [63:0] prod_mag, prod;
  assign pp_lo_d  = ma_q * mb_q[15:0];
  assign pp_hi_d  = ma_q * mb_q[31:16];
  assign prod_mag = {16'd0, pp_lo_q} + {pp_hi_d, 16'd0};
  assign prod     = neg_q_q ? (64'd0 - prod_mag) : prod_mag;

  // Restoring divider: one quotient bit per cycle
  logic [31:0] rem_q, quo_q;
  logic [4:0]  cnt_q;
  logic [32:0] trial;
  logic [31:0] rem_n, quo_n, q_fin, r_fin;
  assign trial = {rem_q, quo_q[31]} - {1'b0, mb_q};
  assign rem_n = trial[32] ? {rem_q[30:0], quo_q[31]} : trial[31:0];
  assign quo_n = {quo_q[30:0], !trial[32]};
  assign q_fin = neg_q_q ? (32'd0 - quo_n) : quo_n;
  assign r_fin = neg_r_q ? (32'd0 - rem_n) : rem_n;

  // Classify the item for the controller and flag the last divide step
  always_comb begin
    sts_o.kind     = KIND_SIMPLE;
    sts_o.div_last = (cnt_q == 5'd31);
    if (op == OP_SPECIAL) begin
      if (fn == FN_MULT || fn == FN_MULTU) sts_o.kind = KIND_MUL;
      else if ((fn == FN_DIV || fn == FN_DIVU) && b != 32'd0) sts_o.kind = KIND_DIV;
    end
  end

  // Decode and compute the result captured at load
  always_comb begin
    logic taken;
    res_d = '0;
    res_d.next_pc = seq;
    taken = 1'b0;
    if (op == OP_SPECIAL) begin
      res_d.dest_reg  = rd;
      res_d.reg_write = 1'b1;
      case (fn)
        FN_ADD, FN_ADDU: res_d.write_value = a + b;
        FN_SUB, FN_SUBU: res_d.write_value = a - b;
        FN_AND:  res_d.write_value = a & b;
        FN_OR:   res_d.write_value = a | b;
        FN_XOR:  res_d.write_value = a ^ b;
        FN_NOR:  res_d.write_value = ~(a | b);
        FN_SLT:  res_d.write_value = {31'd0, $signed(a) < $signed(b)};
        FN_SLTU: res_d.write_value = {31'd0, a < b};
        FN_SLL:  res_d.write_value = b << sh;
        FN_SRL:  res_d.write_value = b >> sh;
        FN_SRA:  res_d.write_value = $unsigned($signed(b) >>> sh);
        FN_JR: begin
          res_d.reg_write = 1'b0;
          res_d.next_pc   = a;
        end
        FN_JALR: begin
          res_d.write_value = seq;
          res_d.next_pc     = a;
        end
        FN_MFHI: res_d.write_value = hi_q;
        FN_MFLO: res_d.write_value = lo_q;
        default: res_d.reg_write = 1'b0;
      endcase
    end else if (op == OP_J || op == OP_JAL) begin
      res_d.next_pc = {seq[31:28], w[25:0], 2'b00};
      if (op == OP_JAL) begin
        res_d.reg_write   = 1'b1;
        res_d.dest_reg    = 5'd31;
        res_d.write_value = seq;
      end
    end else begin
      res_d.dest_reg = rt;
      case (op)
        OP_ADDI, OP_ADDIU: begin res_d.reg_write = 1'b1; res_d.write_value = ea; end
        OP_SLTI: begin
          res_d.reg_write   = 1'b1;
          res_d.write_value = {31'd0, $signed(a) < $signed(simm)};
        end
        OP_SLTIU: begin res_d.reg_write = 1'b1; res_d.write_value = {31'd0, a < simm}; end
        OP_ANDI: begin res_d.reg_write = 1'b1; res_d.write_value = a & zimm; end
        OP_ORI:  begin res_d.reg_write = 1'b1; res_d.write_value = a | zimm; end
        OP_XORI: begin res_d.reg_write = 1'b1; res_d.write_value = a ^ zimm; end
        OP_LUI:  begin res_d.reg_write = 1'b1; res_d.write_value = {imm, 16'h0000}; end
        OP_LW, OP_LL: begin
          res_d.reg_write = 1'b1; res_d.write_value = ea; res_d.mem_op = MEM_LW;
        end
        OP_LBU: begin res_d.reg_write = 1'b1; res_d.write_value = ea; res_d.mem_op = MEM_LBU; end
        OP_LHU: begin res_d.reg_write = 1'b1; res_d.write_value = ea; res_d.mem_op = MEM_LHU; end
        OP_SB: res_d.mem_op = MEM_SB;
        OP_SH: res_d.mem_op = MEM_SH;
        OP_SW: res_d.mem_op = MEM_SW;
        OP_SC: begin res_d.reg_write = 1'b1; res_d.write_value = 32'd1; res_d.mem_op = MEM_SW; end
        OP_BEQ:  taken = (a == b);
        OP_BNE:  taken = (a != b);
        OP_BLEZ: taken = (a == 32'd0) || a[31];
        OP_BGTZ: taken = (a != 32'd0) && !a[31];
        OP_REGIMM: begin
          if (rt == 5'd0) taken = a[31];
          else if (rt == 5'd1) taken = !a[31];
        end
        default: taken = 1'b0;
      endcase
      if (res_d.mem_op != MEM_NONE) res_d.mem_address = ea;
      if (res_d.mem_op == MEM_SB || res_d.mem_op == MEM_SH || res_d.mem_op == MEM_SW)
        res_d.store_data = b;
      if (taken) res_d.next_pc = btarget;
      res_d.branch_taken = taken;
    end
    if (!res_d.reg_write) begin
      res_d.dest_reg    = '0;
      res_d.write_value = '0;
    end
  end

  // Hold operands, divider state and the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_q    <= res_d;
      ma_q     <= ma_d;
      mb_q     <= mb_d;
      neg_q_q  <= is_signed && (a[31] ^ b[31]);
      neg_r_q  <= is_signed && a[31];
      rem_q    <= '0;
      quo_q    <= ma_d;
      cnt_q    <= '0;
    end
    if (cmd_i.mul_lo) pp_lo_q <= pp_lo_d;
    if (cmd_i.div_step) begin
      rem_q <= rem_n;
      quo_q <= quo_n;
      cnt_q <= cnt_q + 5'd1;
    end
  end

  // Update HI and LO
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q <= '0;
      lo_q <= '0;
    end else if (cmd_i.load && op == OP_SPECIAL && fn == FN_MTHI) begin
      hi_q <= a;
    end else if (cmd_i.load && op == OP_SPECIAL && fn == FN_MTLO) begin
      lo_q <= a;
    end else if (cmd_i.mul_hi) begin
      hi_q <= prod[63:32];
      lo_q <= prod[31:0];
    end else if (cmd_i.div_fin) begin
      hi_q <= r_fin;
      lo_q <= q_fin;
    end
  end

  assign out_o = res_q;

endmodule

// ===== hw/rtl/mips32_execute_unit.sv =====
// Top level: MIPS32 execute unit with HI/LO, multiply and divide sequencing.
// One instruction item is taken at a time. ALU, shift, branch, jump, load/store
// and HI/LO move items need no extra state and the next item can be accepted in the
// following cycle. mult/multu run two 32x16 partial-product steps,
// div/divu with a nonzero divisor run a restoring divider, one
// quotient bit per cycle. The result is held in an output register; a new
// item is taken only once that register is empty or in the cycle its result
// leaves, so a stalled receiver stalls the input. HI/LO are updated when the
// multiply or divide sequence ends, before the next item is accepted.
module mips32_execute_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  mips_exu_in_if.sink    in_if,
  mips_exu_out_if.source out_if
);
  import mips_exu_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  mips_exu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  mips_exu_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.payload),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .out_o  (out_if.payload)
  );

endmodule
